/* sv/sha256_byte_stream_hasher_macros.svh */
// assertion helpers shared by the hasher modules
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SBH_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SBH_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/shabs_pkg.sv */
package shabs_pkg;

   // word queue between front and core
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   typedef struct packed {
      logic [31:0] word;
      logic        blk_end;
      logic        msg_end;
   } qent_type;

   // initial hash value
   function automatic logic [31:0] iv_word(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // rotate right
   function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   // round constants
   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] r;
      case (i)
         6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
         6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
         6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
         6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

/* sv/shabs_front.sv */
module shabs_front
   import shabs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        push_valid,
   output qent_type    push_data,
   input  logic        q_full
);

   logic [5:0]  cnt_ff, cnt_in;
   logic [23:0] wbuf_ff, wbuf_in;
   logic [60:0] total_ff, total_in;
   logic        pad_ff, pad_in;
   logic        sent_ff, sent_in;
   logic        lenok_ff, lenok_in;
   logic [3:0]  widx_ff, widx_in;
   logic        accept;
   logic [31:0] nb;
   logic [3:0]  w;

   assign req_stall = pad_ff | q_full;
   assign accept    = req_valid & ~req_stall;
   assign nb        = {wbuf_ff, req_data_byte};
   assign w         = cnt_ff[5:2];

   // byte packing and padding word generation
   always_comb begin
      cnt_in     = cnt_ff;
      wbuf_in    = wbuf_ff;
      total_in   = total_ff;
      pad_in     = pad_ff;
      sent_in    = sent_ff;
      lenok_in   = lenok_ff;
      widx_in    = widx_ff;
      push_valid = 1'b0;
      push_data  = '0;
      if (accept) begin
         if (req_byte_present) begin
            wbuf_in  = nb[23:0];
            cnt_in   = cnt_ff + 6'd1;
            total_in = total_ff + 61'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               push_valid        = 1'b1;
               push_data.word    = nb;
               push_data.blk_end = (cnt_ff == 6'd63);
            end
         end
         if (req_end_of_message) begin
            pad_in  = 1'b1;
            sent_in = 1'b0;
         end
      end else if (pad_ff && !q_full) begin
         push_valid = 1'b1;
         if (!sent_ff) begin
            case (cnt_ff[1:0])
               2'd0: push_data.word = {8'h80, 24'h0};
               2'd1: push_data.word = {wbuf_ff[7:0], 8'h80, 16'h0};
               2'd2: push_data.word = {wbuf_ff[15:0], 8'h80, 8'h0};
               2'd3: push_data.word = {wbuf_ff[23:0], 8'h80};
               default: push_data.word = '0;
            endcase
            push_data.blk_end = (w == 4'd15);
            // length goes in this block, or in a fresh one when the marker falls in word 14 or 15
            lenok_in          = (w != 4'd14);
            sent_in           = 1'b1;
            widx_in           = w + 4'd1;
         end else begin
            if (lenok_ff && widx_ff == 4'd14) begin
               push_data.word = total_ff[60:29];
            end else if (lenok_ff && widx_ff == 4'd15) begin
               push_data.word = {total_ff[28:0], 3'b000};
            end
            push_data.blk_end = (widx_ff == 4'd15);
            push_data.msg_end = (widx_ff == 4'd15) && lenok_ff;
            widx_in           = widx_ff + 4'd1;
            if (widx_ff == 4'd15) begin
               lenok_in = 1'b1;
               if (lenok_ff) begin
                  pad_in   = 1'b0;
                  cnt_in   = '0;
                  total_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      wbuf_ff  <= wbuf_in;
      lenok_ff <= lenok_in;
      widx_ff  <= widx_in;
      sent_ff  <= sent_in;
      if (reset) begin
         cnt_ff   <= '0;
         total_ff <= '0;
         pad_ff   <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

/* sv/shabs_queue.sv */
`include "sha256_byte_stream_hasher_macros.svh"
module shabs_queue
   import shabs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  qent_type push_data,
   output logic     q_full,
   output logic     q_valid,
   output qent_type q_data,
   input  logic     q_pop
);

   qent_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, rd_ff;
   logic [QPTR_W:0]    count_ff;
   logic               do_push, do_pop;

   assign q_full  = (count_ff == (QPTR_W + 1)'(QDEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data  = mem_ff[rd_ff];
   assign do_push = push_valid & ~q_full;
   assign do_pop  = q_pop & q_valid;

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   `SBH_ASSERT_IMPL(a_no_push_full, push_valid, !q_full, "word pushed into full queue")
   `SBH_ASSERT_IMPL(a_level_bound, 1'b1, count_ff <= (QPTR_W + 1)'(QDEPTH), "queue level overrun")
   `SBH_ASSERT_NEXT(a_level_up, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "level lost")

endmodule

/* sv/shabs_core.sv */
`include "sha256_byte_stream_hasher_macros.svh"
module shabs_core
   import shabs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  qent_type    q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]  state_ff;
   logic [5:0]  rcnt_ff;
   logic [2:0]  oidx_ff;
   logic        msg_ff;
   logic [31:0] hv_ff  [8];
   logic [31:0] v_ff   [8];
   logic [31:0] win_ff [16];
   logic [31:0] s1, ch, t1, s0, maj, ws0, ws1, wnew;
   logic        out_take;

   assign q_pop    = (state_ff == ST_LOAD) & q_valid;
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = hv_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);
   assign out_take        = rsp_valid & ~rsp_stall;

   // one round and the next schedule word
   always_comb begin
      s1   = ror32(v_ff[4], 5'd6) ^ ror32(v_ff[4], 5'd11) ^ ror32(v_ff[4], 5'd25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + s1 + ch + round_k(rcnt_ff) + win_ff[0];
      s0   = ror32(v_ff[0], 5'd2) ^ ror32(v_ff[0], 5'd13) ^ ror32(v_ff[0], 5'd22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      ws0  = ror32(win_ff[1], 5'd7) ^ ror32(win_ff[1], 5'd18) ^ (win_ff[1] >> 3);
      ws1  = ror32(win_ff[14], 5'd17) ^ ror32(win_ff[14], 5'd19) ^ (win_ff[14] >> 10);
      wnew = win_ff[0] + ws0 + win_ff[9] + ws1;
   end

   // working variables and message window
   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= q_data.word;
         if (q_data.blk_end) begin
            msg_ff <= q_data.msg_end;
            for (int i = 0; i < 8; i++) v_ff[i] <= hv_ff[i];
         end
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= wnew;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + s0 + maj;
      end
   end

   // sequencer and hash state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         rcnt_ff  <= '0;
         oidx_ff  <= '0;
         for (int i = 0; i < 8; i++) hv_ff[i] <= iv_word(3'(i));
      end else begin
         case (state_ff)
            ST_LOAD: begin
               rcnt_ff <= '0;
               if (q_pop && q_data.blk_end) state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               rcnt_ff <= rcnt_ff + 6'd1;
               if (rcnt_ff == 6'd63) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) hv_ff[i] <= hv_ff[i] + v_ff[i];
               oidx_ff  <= '0;
               state_ff <= msg_ff ? ST_OUT : ST_LOAD;
            end
            ST_OUT: begin
               if (out_take) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) hv_ff[i] <= iv_word(3'(i));
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   `SBH_ASSERT_NEXT(a_iv_restart, out_take && rsp_last_word, state_ff == ST_LOAD && hv_ff[0] == 32'h6a09e667, "hash not restarted after digest")
   `SBH_ASSERT_NEXT(a_round_end, state_ff == ST_ROUND && rcnt_ff == 6'd63, state_ff == ST_ADD, "compression overran")
   `SBH_ASSERT_NEXT(a_digest_start, state_ff == ST_ADD && msg_ff, rsp_valid && rsp_word_index == 3'd0, "digest not started at word 0")

endmodule

/* sv/sha256_byte_stream_hasher.sv */
// SHA-256 over a byte stream. Each accepted request may carry one message byte and an
// end-of-message mark; at the end of a message the block pads it, finishes the hash
// and returns the digest as eight 32-bit words, index 0 first, the eighth marked last,
// then starts a fresh message. Bytes are accepted one per cycle while the four-word
// queue between the byte packer and the compression core has room and no message is
// being padded. The core takes a block's 16 words from the queue at up to one per
// cycle, then runs the 64 rounds (one round per cycle) and adds the result into the
// hash. It takes no words during the rounds, so the packer stalls once the queue is
// full. Closing a message stalls input while 3 to 18 padding words are queued, one per
// cycle while the queue has room and longer while the core is busy, and the digest
// words are offered one per cycle after the final block while rsp_stall is low.
module sha256_byte_stream_hasher
   import shabs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic     push_valid, q_full, q_valid, q_pop;
   qent_type push_data, q_data;

   // byte packer and padder
   shabs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .push_valid         (push_valid),
      .push_data          (push_data),
      .q_full             (q_full)
   );

   // word queue
   shabs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop)
   );

   // compression core and digest output
   shabs_core u_core (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule
